FILE: rtl/sfcp_pkg.sv
// Package for the sensor frame checksum parser.
// Frame constants, index type and the result struct; no dependencies.
package sfcp_pkg;

  localparam logic [7:0] StartByte = 8'hFF;
  localparam int         FrameLen  = 9;
  localparam int         IdxW      = 4;
  localparam logic [IdxW-1:0] LastIndex = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] HuntIndex = '0;
  localparam logic [IdxW-1:0] HighIndex = IdxW'(2);
  localparam logic [IdxW-1:0] LowIndex  = IdxW'(3);

  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic [15:0] reading;
    logic        checksum_ok;
  } result_t;

endpackage

FILE: rtl/sfcp_frame.sv
// Frame tracker: byte index, running sum and held reading bytes.
// Forms the result of the final byte combinationally. Uses sfcp_pkg.
module sfcp_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        rx_byte,
  input  logic              take,
  output logic              last,
  output sfcp_pkg::result_t res
);
  import sfcp_pkg::*;

  idx_t       idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [7:0] lo_r, lo_nxt;

  // index values past the last one are treated as the final byte
  assign last = (idx_r >= LastIndex);

  always_comb begin
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    if (take) begin
      if (idx_r == HuntIndex) begin
        if (rx_byte == StartByte) begin
          idx_nxt = IdxW'(1);
          sum_nxt = '0;
        end
      end else if (!last) begin
        sum_nxt = sum_r + rx_byte;
        if (idx_r == HighIndex) hi_nxt = rx_byte;
        else if (idx_r == LowIndex) lo_nxt = rx_byte;
        idx_nxt = idx_r + IdxW'(1);
      end else begin
        idx_nxt = HuntIndex;
        sum_nxt = '0;
      end
    end
    res.reading     = {hi_r, lo_r};
    res.checksum_ok = (rx_byte == 8'(8'd0 - sum_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= HuntIndex;
      sum_r <= '0;
      hi_r  <= '0;
      lo_r  <= '0;
    end else begin
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
    end
  end

endmodule

FILE: rtl/sfcp_out_reg.sv
// Result register holding one frame result until the receiver takes it.
// Uses sfcp_pkg for the result struct.
module sfcp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sfcp_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              free,
  output sfcp_pkg::result_t held
);
  import sfcp_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (out_ready) vld_nxt = 1'b0;
    if (load)      vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign held      = res_r;

endmodule

FILE: rtl/sensor_frame_checksum_parser_top.sv
// Top level of the sensor frame checksum parser.
// Instantiates sfcp_frame and sfcp_out_reg; uses sfcp_pkg.
//
// Usage:
//   Input channel in_valid/in_ready/in_rx_byte carries received serial
//   bytes, one per transaction. Bytes are dropped until the start byte
//   0xFF, then eight more bytes complete a frame. Bytes 1..7 are summed
//   mod 256; byte 8 is checked against the negated sum.
//   Output channel out_valid/out_ready carries one transaction per frame:
//   out_reading = {byte2, byte3} and out_checksum_ok.
//   Throughput: one byte per cycle, unless the final byte stalls (see Stall).
//   Latency: the result is valid the cycle after the final byte is accepted.
//   Stall: a pending result blocks only the final byte of the next frame;
//   other bytes are still taken while out_ready is low.
//   Reset (rst_n low, synchronous): hunting for the start byte, running
//   sum and held bytes cleared, no result pending.
module sensor_frame_checksum_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_reading,
  output logic        out_checksum_ok
);
  import sfcp_pkg::*;

  logic    last;
  logic    free;
  logic    take;
  result_t res;
  result_t held;

  assign in_ready = free || !last;
  assign take     = in_valid && in_ready;

  sfcp_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .rx_byte (in_rx_byte),
    .take    (take),
    .last    (last),
    .res     (res)
  );

  sfcp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && last),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .free      (free),
    .held      (held)
  );

  assign out_reading     = held.reading;
  assign out_checksum_ok = held.checksum_ok;

endmodule

FILE: verif/tb_sensor_frame_checksum_parser_top.sv
`timescale 1ns / 100ps
// Testbench for sensor_frame_checksum_parser_top: directed and random byte streams.
// A scoreboard class predicts frame results and checks them. Depends on sfcp_pkg.
module tb_sensor_frame_checksum_parser_top;
  import sfcp_pkg::*;

  class FrameScoreboard;
    idx_t        frame_idx;
    logic [7:0]  byte_sum;
    logic [7:0]  held_high;
    logic [7:0]  held_low;
    result_t     reading_q[$];
    int          errors;

    function new();
      frame_idx = HuntIndex;
      byte_sum  = '0;
      held_high = '0;
      held_low  = '0;
      errors    = 0;
    endfunction

    function void note_byte(logic [7:0] rx);
      result_t r;
      if (frame_idx == HuntIndex) begin
        if (rx == StartByte) begin
          byte_sum  = '0;
          frame_idx = idx_t'(1);
        end
      end else if (frame_idx < LastIndex) begin
        byte_sum = byte_sum + rx;
        if (frame_idx == HighIndex) held_high = rx;
        else if (frame_idx == LowIndex) held_low = rx;
        frame_idx = frame_idx + 1'b1;
      end else begin
        r.reading     = {held_high, held_low};
        r.checksum_ok = (rx == 8'(8'd0 - byte_sum));
        reading_q.push_back(r);
        frame_idx = HuntIndex;
        byte_sum  = '0;
      end
    endfunction

    function void check_result(logic [15:0] reading, logic checksum_ok);
      result_t exp_r;
      if (reading_q.size() == 0) begin
        $error("unexpected result transaction: out_reading %h, out_checksum_ok %b",
               reading, checksum_ok);
        errors++;
        return;
      end
      exp_r = reading_q.pop_front();
      if (reading !== exp_r.reading) begin
        $error("out_reading mismatch: expected %h, actual %h", exp_r.reading, reading);
        errors++;
      end
      if (checksum_ok !== exp_r.checksum_ok) begin
        $error("out_checksum_ok mismatch: expected %b, actual %b",
               exp_r.checksum_ok, checksum_ok);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_reading;
  logic        out_checksum_ok;

  FrameScoreboard sb;
  int          burst_left;
  bit          offering;
  bit          hold_req;
  int          hold_cnt;
  logic [15:0] ready_pat;
  int          pat_age;

  sensor_frame_checksum_parser_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_reading     (out_reading),
    .out_checksum_ok (out_checksum_ok)
  );

  always #2 clk = ~clk;

  // receiver: rotating random stall pattern, refreshed regularly, plus a long hold on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_reading, out_checksum_ok);
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = 200;
        hold_req = 1'b0;
      end
      if (pat_age == 0) begin
        ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        pat_age   = 64;
      end
      pat_age--;
      ready_pat = {ready_pat[0], ready_pat[15:1]};
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ready_pat[0];
      end
    end
  end

  task automatic push_byte(input logic [7:0] rx);
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(rx);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 20);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
      offering = 1'b1;
    end
  endtask

  // body byte i of 0..6 is frame byte i+1
  task automatic push_frame(input logic [55:0] body, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] check;
    sum = '0;
    push_byte(StartByte);
    for (int i = 0; i < 7; i++) begin
      sum = sum + body[8*(6-i) +: 8];
      push_byte(body[8*(6-i) +: 8]);
    end
    check = 8'(8'd0 - sum);
    if (!good_sum) check = check ^ 8'($urandom_range(1, 255));
    push_byte(check);
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.reading_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int  frame_bytes;
    int  n_frames;
    bit  held;
    bit  paused;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    out_ready  = 1'b0;
    hold_req   = 1'b0;
    hold_cnt   = 0;
    pat_age    = 0;
    ready_pat  = 16'hFFFF;
    offering   = 1'b0;
    burst_left = 5;
    frame_bytes = 0;
    n_frames    = 0;
    held        = 1'b0;
    paused      = 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // noise while hunting, all-0xFF body, zero body with bad sum, sum needing 0xFF
    push_byte(8'h00);
    push_byte(8'h7E);
    push_frame({7{8'hFF}}, 1'b1);
    push_frame('0, 1'b0);
    push_frame({8'h01, 48'h0}, 1'b1);
    wait_drained();

    while (frame_bytes < 600) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 254)));
        1: begin
          push_byte(StartByte);
          frame_bytes++;
          repeat ($urandom_range(0, 7)) begin
            push_byte(8'($urandom));
            frame_bytes++;
          end
        end
        default: begin
          push_frame(56'({$urandom, $urandom}), $urandom_range(0, 3) != 0);
          frame_bytes += 9;
          n_frames++;
        end
      endcase
      if (n_frames >= 15 && !held) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (n_frames >= 35 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.reading_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
